// File: rtl/nearest_palette_color_chebyshev_macros.svh
// Assertion macros for the nearest palette color block.
// Every check is sampled on the rising edge of clk and is off while arst_n is low.
`ifndef NEAREST_PALETTE_COLOR_CHEBYSHEV_MACROS_SVH
`define NEAREST_PALETTE_COLOR_CHEBYSHEV_MACROS_SVH

// Same-cycle implication.
`define NPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define NPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/npc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npc_pkg;

	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W         = 5;
	localparam int CHAN_W        = 8;
	// One extra bit so that an entry outside the searched range can never win.
	localparam int DIST_W        = CHAN_W + 1;
	localparam logic [DIST_W-1:0] DIST_NONE = {1'b1, {CHAN_W{1'b0}}};

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [DIST_W-1:0] distance;
	} cand_t;

	typedef logic [3*CHAN_W-1:0] rgb_t;

	// Palette entries packed as {red, green, blue}.
	localparam rgb_t PALETTE [TABLE_ENTRIES] = '{
		24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555,
		24'hFED3C7, 24'hFFC4CE, 24'hFAAC8E, 24'hFF8B83,
		24'hF44336, 24'hE91E63, 24'hE2669E, 24'h9C27B0,
		24'h673AB7, 24'h3F51B5, 24'h004670, 24'h057197,
		24'h2196F3, 24'h00BCD4, 24'h3BE5DB, 24'h97FDDC,
		24'h167300, 24'h37A93C, 24'h89E642, 24'hD7FF07,
		24'hFFF6D1, 24'hF8CB8C, 24'hFFEB3B, 24'hFFC107,
		24'hFF9800, 24'hFF5722, 24'hB83F27, 24'h795548
	};

endpackage

`default_nettype wire

// File: rtl/npc_pixel_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface npc_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// File: rtl/npc_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface npc_result_if;
	logic       valid;
	logic       ready;
	logic [4:0] palette_index;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic [7:0] min_distance;

	modport source (output valid, output palette_index, output out_red, output out_green,
		output out_blue, output min_distance, input ready);
	modport sink   (input valid, input palette_index, input out_red, input out_green,
		input out_blue, input min_distance, output ready);
endinterface

`default_nettype wire

// File: rtl/npc_reduce.sv
`timescale 1ns / 1ps
`default_nettype none

module npc_reduce
	import npc_pkg::*;
#(
	parameter int N_IN   = 32,
	parameter int LEVELS = 2,
	localparam int N_OUT = N_IN >> LEVELS
) (
	input  wire cand_t [N_IN-1:0]  cands,
	output cand_t [N_OUT-1:0]      winners
);

	cand_t lvl [LEVELS+1][N_IN];

	// Pairwise compare tree. The higher-indexed candidate of a pair wins only
	// on a strictly smaller distance, so ties keep the lower palette index.
	always_comb begin
		for (int l = 0; l <= LEVELS; l++) begin
			for (int k = 0; k < N_IN; k++) begin
				lvl[l][k] = '0;
			end
		end
		for (int k = 0; k < N_IN; k++) begin
			lvl[0][k] = cands[k];
		end
		for (int l = 0; l < LEVELS; l++) begin
			for (int k = 0; k < (N_IN >> (l + 1)); k++) begin
				if (lvl[l][2*k+1].distance < lvl[l][2*k].distance) begin
					lvl[l+1][k] = lvl[l][2*k+1];
				end else begin
					lvl[l+1][k] = lvl[l][2*k];
				end
			end
		end
		for (int k = 0; k < N_OUT; k++) begin
			winners[k] = lvl[LEVELS][k];
		end
	end

endmodule

`default_nettype wire

// File: rtl/nearest_palette_color_chebyshev.sv
// Nearest palette color by Chebyshev distance.
//
// The pixel channel (sink) takes one RGB pixel per item; the result channel
// (source) gives the index of the nearest of the first PALETTE_SIZE entries of
// the built-in 32-color palette (capped at 32), that entry's RGB value and
// the distance, the largest absolute channel difference. Ties go to the lower
// index. Both channels use valid/ready; an item moves when both are high.
//
// Throughput is one pixel per clock while the receiver takes every result.
// Results pass through four register stages: stage 1 holds all 32
// distances from parallel distance units, stages 2 and 3 each run two levels
// of the compare tree, and stage 4 runs the last level and looks the winner's
// color up in the table.
//
// Each stage has its own valid bit and takes a new item when it is empty or
// when the next stage takes its current one, so a stalled receiver fills the
// pipeline before pixel.ready drops and no item is lost or repeated.
// Reset clears only the valid bits; there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module nearest_palette_color_chebyshev
	import npc_pkg::*;
#(
	parameter int PALETTE_SIZE = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	npc_pixel_if.sink     pixel,
	npc_result_if.source  result
);

	localparam int COUNT = (PALETTE_SIZE > TABLE_ENTRIES) ? TABLE_ENTRIES :
		((PALETTE_SIZE < 1) ? 1 : PALETTE_SIZE);

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [CHAN_W-1:0] max3(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] c);
		logic [CHAN_W-1:0] m;
		m = (b > a) ? b : a;
		return (c > m) ? c : m;
	endfunction

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic rdy2, rdy3, rdy4;

	cand_t [TABLE_ENTRIES-1:0] dist_c;
	cand_t [TABLE_ENTRIES-1:0] cand_s1;
	cand_t [7:0]               red8_c;
	cand_t [7:0]               cand_s2;
	cand_t [1:0]               red2_c;
	cand_t [1:0]               cand_s3;
	cand_t [0:0]               red1_c;
	logic [IDX_W-1:0]          idx_s4;
	logic [CHAN_W-1:0]         dist_s4;
	rgb_t                      rgb_s4;

	assign rdy4        = !v4_s4 || result.ready;
	assign rdy3        = !v3_s3 || rdy4;
	assign rdy2        = !v2_s2 || rdy3;
	assign pixel.ready = !v1_s1 || rdy2;

	for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_dist
		if (k < COUNT) begin : g_used
			assign dist_c[k].idx      = IDX_W'(k);
			assign dist_c[k].distance = {1'b0, max3(
				abs_diff(pixel.red,   PALETTE[k][3*CHAN_W-1:2*CHAN_W]),
				abs_diff(pixel.green, PALETTE[k][2*CHAN_W-1:CHAN_W]),
				abs_diff(pixel.blue,  PALETTE[k][CHAN_W-1:0]))};
		end else begin : g_unused
			assign dist_c[k].idx      = IDX_W'(k);
			assign dist_c[k].distance = DIST_NONE;
		end
	end

	npc_reduce #(.N_IN(TABLE_ENTRIES), .LEVELS(2)) u_reduce_a (
		.cands   (cand_s1),
		.winners (red8_c)
	);

	npc_reduce #(.N_IN(8), .LEVELS(2)) u_reduce_b (
		.cands   (cand_s2),
		.winners (red2_c)
	);

	npc_reduce #(.N_IN(2), .LEVELS(1)) u_reduce_c (
		.cands   (cand_s3),
		.winners (red1_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (pixel.ready) v1_s1 <= pixel.valid;
			if (rdy2)        v2_s2 <= v1_s1;
			if (rdy3)        v3_s3 <= v2_s2;
			if (rdy4)        v4_s4 <= v3_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (pixel.ready && pixel.valid) cand_s1 <= dist_c;
		if (rdy2 && v1_s1)              cand_s2 <= red8_c;
		if (rdy3 && v2_s2)              cand_s3 <= red2_c;
		if (rdy4 && v3_s3) begin
			idx_s4  <= red1_c[0].idx;
			dist_s4 <= red1_c[0].distance[CHAN_W-1:0];
			rgb_s4  <= PALETTE[red1_c[0].idx];
		end
	end

	assign result.valid         = v4_s4;
	assign result.palette_index = idx_s4;
	assign result.out_red       = rgb_s4[3*CHAN_W-1:2*CHAN_W];
	assign result.out_green     = rgb_s4[2*CHAN_W-1:CHAN_W];
	assign result.out_blue      = rgb_s4[CHAN_W-1:0];
	assign result.min_distance  = dist_s4;

endmodule

`default_nettype wire

// File: rtl/npc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_palette_color_chebyshev_macros.svh"

module npc_checker
	import npc_pkg::*;
#(
	parameter int PALETTE_SIZE = 32
) (
	input wire       clk,
	input wire       arst_n,
	input wire       in_ready,
	input wire       out_valid,
	input wire       out_ready,
	input wire [4:0] palette_index,
	input wire [7:0] out_red,
	input wire [7:0] out_green,
	input wire [7:0] out_blue,
	input wire [7:0] min_distance
);

	localparam int COUNT = (PALETTE_SIZE > TABLE_ENTRIES) ? TABLE_ENTRIES :
		((PALETTE_SIZE < 1) ? 1 : PALETTE_SIZE);

	logic        rgb_ok;
	logic        idx_ok;
	logic [36:0] payload;

	assign rgb_ok  = ({out_red, out_green, out_blue} == PALETTE[palette_index]);
	assign idx_ok  = (int'(palette_index) < COUNT);
	assign payload = {palette_index, out_red, out_green, out_blue, min_distance};

	`NPC_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(payload), "result item changed while stalled")
	`NPC_ASSERT_NOW(a_rgb_matches_index, out_valid, rgb_ok, "result color does not match palette entry")
	`NPC_ASSERT_NOW(a_index_in_range, out_valid, idx_ok, "result index beyond searched palette")
	`NPC_ASSERT_NOW(a_stall_only_when_full, !in_ready, out_valid && !out_ready, "input stalled while output is free")

endmodule

bind nearest_palette_color_chebyshev npc_checker #(.PALETTE_SIZE(PALETTE_SIZE)) u_npc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (pixel.ready),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.palette_index (result.palette_index),
	.out_red       (result.out_red),
	.out_green     (result.out_green),
	.out_blue      (result.out_blue),
	.min_distance  (result.min_distance)
);

`default_nettype wire

// File: test/tb_nearest_palette_color_chebyshev.sv
`timescale 1ns / 1ps

module tb_nearest_palette_color_chebyshev;
	import npc_pkg::*;

	localparam int PALETTE_SIZE = 32;
	localparam int RANDOM_PIXELS = 700;
	localparam int IDLE_PCT = 37;
	localparam int CYCLE_LIMIT = 200000;
	// Extra cycles to run before the final verdict.
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [IDX_W-1:0]  idx;
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] distance;
	} palette_match_t;

	class palette_scoreboard;
		palette_match_t expected_q[$];
		int searched;
		int mismatches;
		int pixels_seen;
		int results_seen;
		int exact_hits;
		int hit_count[TABLE_ENTRIES];

		function new(int palette_size);
			searched = palette_size;
			if (searched < 1)
				searched = 1;
			if (searched > TABLE_ENTRIES)
				searched = TABLE_ENTRIES;
			mismatches = 0;
			pixels_seen = 0;
			results_seen = 0;
			exact_hits = 0;
			foreach (hit_count[i])
				hit_count[i] = 0;
		endfunction

		function int channel_gap(int a, int b);
			return (a > b) ? a - b : b - a;
		endfunction

		function int chebyshev_distance(int r, int g, int b, rgb_t entry);
			int d;
			int e;
			int f;
			d = channel_gap(r, entry[23:16]);
			e = channel_gap(g, entry[15:8]);
			f = channel_gap(b, entry[7:0]);
			if (e > d)
				d = e;
			if (f > d)
				d = f;
			return d;
		endfunction

		function palette_match_t nearest_color(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			palette_match_t m;
			int best_idx;
			int best_dist;
			int d;
			best_idx = 0;
			best_dist = chebyshev_distance(r, g, b, PALETTE[0]);
			// A later entry wins only on a strictly smaller distance.
			for (int i = 1; i < searched; i++) begin
				d = chebyshev_distance(r, g, b, PALETTE[i]);
				if (d < best_dist) begin
					best_dist = d;
					best_idx = i;
				end
			end
			m.idx = best_idx[IDX_W-1:0];
			m.red = PALETTE[best_idx][23:16];
			m.green = PALETTE[best_idx][15:8];
			m.blue = PALETTE[best_idx][7:0];
			m.distance = best_dist[CHAN_W-1:0];
			return m;
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			palette_match_t m;
			m = nearest_color(r, g, b);
			expected_q.push_back(m);
			pixels_seen++;
			hit_count[m.idx]++;
			if (m.distance == 0)
				exact_hits++;
		endfunction

		function void check_result(logic [4:0] idx, logic [7:0] r, logic [7:0] g,
			logic [7:0] b, logic [7:0] distance);
			palette_match_t m;
			results_seen++;
			if (expected_q.size() == 0) begin
				$error("result item with no pixel waiting: index %0d", idx);
				mismatches++;
				return;
			end
			m = expected_q.pop_front();
			if (idx !== m.idx) begin
				$error("palette_index: expected %0d, actual %0d", m.idx, idx);
				mismatches++;
			end
			if (r !== m.red) begin
				$error("out_red: expected %0d, actual %0d", m.red, r);
				mismatches++;
			end
			if (g !== m.green) begin
				$error("out_green: expected %0d, actual %0d", m.green, g);
				mismatches++;
			end
			if (b !== m.blue) begin
				$error("out_blue: expected %0d, actual %0d", m.blue, b);
				mismatches++;
			end
			if (distance !== m.distance) begin
				$error("min_distance: expected %0d, actual %0d", m.distance, distance);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int cycle_count = 0;
	rgb_t pixel_q[$];
	palette_scoreboard board;

	npc_pixel_if pix();
	npc_result_if res();

	nearest_palette_color_chebyshev #(
		.PALETTE_SIZE(PALETTE_SIZE)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixel(pix),
		.result(res)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pix.valid && pix.ready)
			board.note_pixel(pix.red, pix.green, pix.blue);
	end

	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready)
			board.check_result(res.palette_index, res.out_red, res.out_green,
				res.out_blue, res.min_distance);
	end

	// Receiver: random stalls, one long hold-off to back the pipeline up into
	// the pixel channel, and a stretch where it always takes the item.
	initial begin
		int taken;
		int hold;
		bit held;
		taken = 0;
		hold = 0;
		held = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res.valid && res.ready)
				taken++;
			if (taken == 200 && !held) begin
				hold = 80;
				held = 1;
			end
			if (hold > 0) begin
				hold--;
				res.ready <= 1'b0;
			end else if (taken >= 350 && taken < 500) begin
				res.ready <= 1'b1;
			end else begin
				res.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	function automatic logic [7:0] jitter(logic [7:0] base, int span);
		int v;
		v = int'(base) + $urandom_range(2 * span) - span;
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[7:0];
	endfunction

	function automatic logic [7:0] midpoint(logic [7:0] a, logic [7:0] b);
		return 8'((9'(a) + 9'(b)) >> 1);
	endfunction

	task automatic build_pixels();
		rgb_t e0;
		rgb_t e1;
		int mode;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		// Channel extremes and the gray axis around the black and gray entries.
		pixel_q.push_back(24'h000000);
		pixel_q.push_back(24'hFFFFFF);
		pixel_q.push_back(24'hFF0000);
		pixel_q.push_back(24'h00FF00);
		pixel_q.push_back(24'h0000FF);
		pixel_q.push_back(24'hFFFF00);
		pixel_q.push_back(24'h00FFFF);
		pixel_q.push_back(24'hFF00FF);
		pixel_q.push_back(24'h808080);
		pixel_q.push_back(24'h7F7F7F);
		pixel_q.push_back(24'h2A2A2A);
		pixel_q.push_back(24'h2B2B2B);
		// Exact palette entries give a zero distance.
		for (int i = 0; i < TABLE_ENTRIES; i += 4)
			pixel_q.push_back(PALETTE[i + 3]);
		// Points halfway between two neighbouring entries, each channel rounded down.
		for (int i = 0; i < 4; i++) begin
			e0 = PALETTE[i];
			e1 = PALETTE[i + 1];
			pixel_q.push_back({midpoint(e0[23:16], e1[23:16]),
				midpoint(e0[15:8], e1[15:8]), midpoint(e0[7:0], e1[7:0])});
		end
		for (int n = 0; n < RANDOM_PIXELS; n++) begin
			mode = $urandom_range(99);
			e0 = PALETTE[$urandom_range(TABLE_ENTRIES - 1)];
			e1 = PALETTE[$urandom_range(TABLE_ENTRIES - 1)];
			if (mode < 40) begin
				r = 8'($urandom);
				g = 8'($urandom);
				b = 8'($urandom);
			end else if (mode < 75) begin
				r = jitter(e0[23:16], 6);
				g = jitter(e0[15:8], 6);
				b = jitter(e0[7:0], 6);
			end else if (mode < 90) begin
				r = jitter(midpoint(e0[23:16], e1[23:16]), 1);
				g = jitter(midpoint(e0[15:8], e1[15:8]), 1);
				b = jitter(midpoint(e0[7:0], e1[7:0]), 1);
			end else begin
				r = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
				g = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
				b = ($urandom_range(2) == 0) ? 8'h00 : ($urandom_range(1) ? 8'hFF : 8'($urandom));
			end
			pixel_q.push_back({r, g, b});
		end
	endtask

	// Sender: random gaps except for a middle stretch that streams back to back.
	task automatic drive_pixels();
		bit calm;
		for (int n = 0; n < pixel_q.size(); n++) begin
			calm = (n >= 350 && n < 500);
			while (!calm && $urandom_range(99) < IDLE_PCT) begin
				pix.valid <= 1'b0;
				@(posedge clk);
			end
			pix.valid <= 1'b1;
			pix.red <= pixel_q[n][23:16];
			pix.green <= pixel_q[n][15:8];
			pix.blue <= pixel_q[n][7:0];
			@(posedge clk);
			while (!pix.ready)
				@(posedge clk);
		end
		pix.valid <= 1'b0;
	endtask

	initial begin
		int chosen;
		pix.valid = 1'b0;
		pix.red = 8'h00;
		pix.green = 8'h00;
		pix.blue = 8'h00;
		arst_n = 1'b0;
		board = new(PALETTE_SIZE);
		build_pixels();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		drive_pixels();
		do
			@(posedge clk);
		while (board.pending() != 0 || board.pixels_seen < pixel_q.size());
		repeat (DRAIN_CYCLES) @(posedge clk);

		chosen = 0;
		foreach (board.hit_count[i])
			if (board.hit_count[i] != 0)
				chosen++;
		$display("Sent %0d pixels and checked %0d result items in %0d cycles.",
			board.pixels_seen, board.results_seen, cycle_count);
		$display("%0d of %0d palette entries were chosen, %0d pixels hit an entry exactly.",
			chosen, TABLE_ENTRIES, board.exact_hits);
		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
